// ----- design/oaid_pkg.sv -----
// ----------------------------------------------------------------------------
// oaid_pkg
// Shared constants, codes and controller/datapath interface types for the
// ordered array with insert, delete and read at an index.
// ----------------------------------------------------------------------------
package oaid_pkg;

	// array geometry
	localparam int DEPTH = 16;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int DW    = 32;

	// command field width and codes
	localparam int CMDW = 2;
	localparam logic [CMDW-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMDW-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMDW-1:0] CMD_READ   = 2'd2;

	// status field width and codes
	localparam int STW = 2;
	localparam logic [STW-1:0] ST_OK    = 2'd0;
	localparam logic [STW-1:0] ST_FULL  = 2'd1;
	localparam logic [STW-1:0] ST_RANGE = 2'd2;

	// stream word widths, padded to whole bytes
	localparam int IN_BITS  = CMDW + AW + DW;
	localparam int IN_TW    = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = STW + DW + CW;
	localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

	// result fields held by the controller until the result is loaded
	typedef struct packed {
		logic [STW-1:0] status;
		logic           inc;
		logic           dec;
		logic           use_rd;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture the request and set the pointer
		logic rd_en;    // read the entry under the pointer
		logic mv;       // the read feeds a move one place over
		logic step;     // advance the pointer
		logic put;      // write the request value at its slot
		logic out_load; // load the result register, update the count
		res_t res;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [CMDW-1:0] cmd;
		logic            full;
		logic            idx_ge_cnt;
		logic            del_single;
		logic            shift_last;
	} dp_stat_t;

endpackage

// ----- design/oaid_dp.sv -----
// ----------------------------------------------------------------------------
// oaid_dp
// Datapath: entry memory with registered read, count, request registers,
// move pointer with a one-stage move pipeline, and the result register.
// ----------------------------------------------------------------------------
module oaid_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [oaid_pkg::CMDW-1:0] cmd,
	input  logic [oaid_pkg::AW-1:0]   index,
	input  logic [oaid_pkg::DW-1:0]   value,
	input  oaid_pkg::ctl_cmd_t        ctl,
	output oaid_pkg::dp_stat_t        stat,
	output logic [oaid_pkg::STW-1:0]  status,
	output logic [oaid_pkg::DW-1:0]   read_value,
	output logic [oaid_pkg::CW-1:0]   count
);
	import oaid_pkg::*;

	logic [DW-1:0]   mem [DEPTH];
	logic [DW-1:0]   rd_data_q;
	logic [CW-1:0]   cnt_q;
	logic [CMDW-1:0] cmd_q;
	logic [AW-1:0]   idx_q;
	logic [DW-1:0]   val_q;
	logic [AW-1:0]   ptr_q;
	logic            mv_s1;
	logic [AW-1:0]   wa_s1;
	logic [AW-1:0]   eff_idx;
	logic [CW-1:0]   cnt_next;
	logic [STW-1:0]  status_q;
	logic [DW-1:0]   read_value_q;
	logic [CW-1:0]   count_q;

	// decisions on the captured request
	assign stat.cmd        = cmd_q;
	assign stat.full       = (cnt_q == CW'(DEPTH));
	assign stat.idx_ge_cnt = ({1'b0, idx_q} >= cnt_q);
	assign stat.del_single = (({1'b0, idx_q} + CW'(1)) == cnt_q);
	assign stat.shift_last = (cmd_q == CMD_INSERT) ? (ptr_q == idx_q)
	                                               : (({1'b0, ptr_q} + CW'(1)) == cnt_q);

	// insert slot, clamped to the end of the array
	assign eff_idx = stat.idx_ge_cnt ? cnt_q[AW-1:0] : idx_q;

	// count after the current request
	always_comb begin
		cnt_next = cnt_q;
		if (ctl.res.inc) begin
			cnt_next = cnt_q + CW'(1);
		end else if (ctl.res.dec) begin
			cnt_next = cnt_q - CW'(1);
		end
	end

	// request capture and move pointer
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			idx_q <= index;
			val_q <= value;
			case (cmd)
				CMD_INSERT: ptr_q <= cnt_q[AW-1:0] - AW'(1);
				CMD_DELETE: ptr_q <= index + AW'(1);
				default:    ptr_q <= index;
			endcase
		end else if (ctl.step) begin
			if (cmd_q == CMD_INSERT) begin
				ptr_q <= ptr_q - AW'(1);
			end else begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	// move pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1 <= 1'b0;
		end else begin
			mv_s1 <= ctl.rd_en & ctl.mv;
		end
	end

	// move target: one place up for insert, one place down for delete
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			wa_s1 <= (cmd_q == CMD_INSERT) ? ptr_q + AW'(1) : ptr_q - AW'(1);
		end
	end

	// entry memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mv_s1) begin
			mem[wa_s1] <= rd_data_q;
		end else if (ctl.put) begin
			mem[eff_idx] <= val_q;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[ptr_q];
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.out_load) begin
			cnt_q <= cnt_next;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			status_q     <= ctl.res.status;
			read_value_q <= ctl.res.use_rd ? rd_data_q : '0;
			count_q      <= cnt_next;
		end
	end

	assign status     = status_q;
	assign read_value = read_value_q;
	assign count      = count_q;

endmodule

// ----- design/oaid_ctrl.sv -----
// ----------------------------------------------------------------------------
// oaid_ctrl
// Controller: sequences one request at a time through decode, entry moves
// and the final write, and owns the result valid flag.
// ----------------------------------------------------------------------------
module oaid_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  oaid_pkg::dp_stat_t   stat,
	output oaid_pkg::ctl_cmd_t   ctl
);
	import oaid_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_PUT   = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	res_t       res_q;
	res_t       res_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// next state and datapath commands
	always_comb begin
		state_d      = state_q;
		res_d        = res_q;
		ctl          = '0;
		ctl.res      = res_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				res_d   = '{status: ST_RANGE, inc: 1'b0, dec: 1'b0, use_rd: 1'b0};
				state_d = S_DONE;
				case (stat.cmd)
					CMD_INSERT: begin
						if (stat.full) begin
							res_d.status = ST_FULL;
						end else begin
							res_d.status = ST_OK;
							res_d.inc    = 1'b1;
							state_d      = stat.idx_ge_cnt ? S_PUT : S_SHIFT;
						end
					end
					CMD_DELETE: begin
						if (!stat.idx_ge_cnt) begin
							res_d.status = ST_OK;
							res_d.dec    = 1'b1;
							if (!stat.del_single) begin
								state_d = S_SHIFT;
							end
						end
					end
					CMD_READ: begin
						if (!stat.idx_ge_cnt) begin
							res_d.status = ST_OK;
							res_d.use_rd = 1'b1;
							ctl.rd_en    = 1'b1;
						end
					end
					default: begin
						res_d.status = ST_RANGE;
					end
				endcase
			end
			S_SHIFT: begin
				ctl.rd_en = 1'b1;
				ctl.mv    = 1'b1;
				ctl.step  = 1'b1;
				if (stat.shift_last) begin
					state_d = (stat.cmd == CMD_INSERT) ? S_DRAIN : S_DONE;
				end
			end
			S_DRAIN: begin
				// last move lands this cycle
				state_d = S_PUT;
			end
			S_PUT: begin
				ctl.put = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state, pending result fields and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/ordered_array_insert_delete.sv -----
// Sequence: a taken request is decoded; a read, a rejected request or a delete of the last
// entry then loads the result register, a delete first moves each later entry down, and an
// insert first moves each entry from index on up (count - index of them), then writes the
// value at its slot; an insert at or past the end only writes. One request at a time; the
// entry memory moves one entry a cycle and the result waits while the output is held.
// Reset: arst_n clears the count and the controller; entries are undefined until written.
// ----------------------------------------------------------------------------
// ordered_array_insert_delete
// Compact ordered array of signed 32-bit entries with insert, delete and
// read at an index; one result per request.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [1:0] cmd, [5:2] index, [37:6] value, [39:38] zero
	input  logic [oaid_pkg::IN_TW-1:0]    s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [1:0] status, [33:2] read_value, [38:34] count, [39] zero
	output logic [oaid_pkg::OUT_TW-1:0]   m_axis_tdata
);
	import oaid_pkg::*;

	ctl_cmd_t       ctl;
	dp_stat_t       stat;
	logic [STW-1:0] status;
	logic [DW-1:0]  read_value;
	logic [CW-1:0]  count;

	// request sequencing
	oaid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// entry storage and result
	oaid_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (s_axis_tdata[CMDW-1:0]),
		.index      (s_axis_tdata[CMDW+AW-1:CMDW]),
		.value      (s_axis_tdata[CMDW+AW+DW-1:CMDW+AW]),
		.ctl        (ctl),
		.stat       (stat),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

	// result word packing
	assign m_axis_tdata = {{(OUT_TW - OUT_BITS){1'b0}}, count, read_value, status};

endmodule
